/* design/r2i_pkg.sv */
// Shared types and constants for the raster 2-D IIR filter.
`timescale 1ns / 1ps
package r2i_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int WID_W        = COL_W + 1;
  localparam int LW_W         = 11;
  localparam int GAIN_W       = 16;
  localparam int PIX_W        = 8;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int PROD_W       = GAIN_W + PIX_W;
  localparam int ACC_W        = PROD_W + 3;
  localparam int FRAC_W       = 16;
  // stages between the line buffer read and its write-back
  localparam int HAZARD_DEPTH = 3;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LW_W-1:0]   LINE_WIDTH_RST    = LW_W'(1024);
  localparam logic [GAIN_W-1:0] INPUT_GAIN_RST    = GAIN_W'(655);
  localparam logic [GAIN_W-1:0] NEIGHBOR_GAIN_RST = GAIN_W'(58982);
  localparam logic [GAIN_W-1:0] DIAGONAL_GAIN_RST = GAIN_W'(53084);
  localparam logic [PIX_W-1:0]  PIX_MAX           = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_WIDTH    = 2'd0,
    CFG_INPUT_GAIN    = 2'd1,
    CFG_NEIGHBOR_GAIN = 2'd2,
    CFG_DIAGONAL_GAIN = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0] a;
    logic [GAIN_W-1:0] b;
    logic [GAIN_W-1:0] c;
  } r2i_gains_t;

  // one classified request on its way to the back end
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [COL_W-1:0] col;
    logic             first_row;
    logic             last;
    logic             narrow;
  } r2i_item_t;

  typedef struct packed {
    logic             use_left;
    logic             last;
    logic [COL_W-1:0] col;
  } r2i_ctl_t;

endpackage

/* design/raster_2d_iir_filter.sv */
// Top level of the raster-order 2-D first-order IIR filter.
// A popped request passes the s1, s2, s3 and output registers in that order.
// Throughput: one pixel per cycle for line_width of 4 or more while not stalled;
// narrower rows wait until the line buffer read-to-write-back stages are empty.
// Reset: async active low; registers return to defaults, position to the top
// row; the line buffer is not cleared (no clearing pass, entries written first).
`timescale 1ns / 1ps
module raster_2d_iir_filter import r2i_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // pixel requests in
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [PIX_W-1:0]     pixel_in_i,
  input  logic                 frame_start_i,
  // filtered pixels out
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [PIX_W-1:0]     pixel_out_o,
  output logic                 row_end_o
);

  logic [LW_W-1:0] line_width_q;
  r2i_gains_t      gains_q;

  logic      push, pop, q_full, q_empty;
  r2i_item_t item, head;

  // configuration registers; user must write them only while the block is idle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LINE_WIDTH_RST;
      gains_q.a    <= INPUT_GAIN_RST;
      gains_q.b    <= NEIGHBOR_GAIN_RST;
      gains_q.c    <= DIAGONAL_GAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LINE_WIDTH:    line_width_q <= cfg_data_i[LW_W-1:0];
        CFG_INPUT_GAIN:    gains_q.a    <= cfg_data_i;
        CFG_NEIGHBOR_GAIN: gains_q.b    <= cfg_data_i;
        CFG_DIAGONAL_GAIN: gains_q.c    <= cfg_data_i;
        default:           line_width_q <= line_width_q;
      endcase
    end
  end

  // only a full queue holds off new requests
  assign in_stall_o = q_full;

  // front: position tracking and classification
  r2i_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .line_width_i  (line_width_q),
    .in_valid_i    (in_valid_i),
    .pixel_in_i    (pixel_in_i),
    .frame_start_i (frame_start_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .item_o        (item)
  );

  // decouples input acceptance from back-end stalls
  r2i_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (item),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head)
  );

  // back: line buffer read, products, partial sum, left feedback and clip
  r2i_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .gains_i     (gains_q),
    .q_empty_i   (q_empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_out_o (pixel_out_o),
    .row_end_o   (row_end_o)
  );

endmodule

/* design/r2i_front.sv */
// Front end: accepts pixels and tags them with column, row and hazard flags.
`timescale 1ns / 1ps
module r2i_front import r2i_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [LW_W-1:0] line_width_i,
  input  logic            in_valid_i,
  input  logic [PIX_W-1:0] pixel_in_i,
  input  logic            frame_start_i,
  input  logic            q_full_i,
  output logic            push_o,
  output r2i_item_t       item_o
);

  logic [COL_W-1:0] pos_q, pos_d;
  logic             first_q, first_d;
  logic [WID_W-1:0] w_eff;
  logic [COL_W-1:0] pos0, col;
  logic             first0, wrap, first, last;
  logic [WID_W-1:0] col_inc;

  // width of 0 acts as 1, above the buffer size as the buffer size
  always_comb begin
    if (line_width_i == '0) begin
      w_eff = WID_W'(1);
    end else if (32'(line_width_i) > MAX_WIDTH) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = WID_W'(line_width_i);
    end
  end

  always_comb begin
    pos0    = frame_start_i ? '0 : pos_q;
    first0  = frame_start_i ? 1'b1 : first_q;
    wrap    = {1'b0, pos0} >= w_eff;
    col     = wrap ? '0 : pos0;
    first   = wrap ? 1'b0 : first0;
    col_inc = {1'b0, col} + WID_W'(1);
    last    = col_inc >= w_eff;
    pos_d   = last ? '0 : col_inc[COL_W-1:0];
    first_d = last ? 1'b0 : first;
  end

  assign push_o           = in_valid_i && !q_full_i;
  assign item_o.pixel     = pixel_in_i;
  assign item_o.col       = col;
  assign item_o.first_row = first;
  assign item_o.last      = last;
  assign item_o.narrow    = w_eff <= WID_W'(HAZARD_DEPTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      first_q <= 1'b1;
    end else if (push_o) begin
      pos_q   <= pos_d;
      first_q <= first_d;
    end
  end

endmodule

/* design/r2i_queue.sv */
// Short request queue between the front and back ends.
`timescale 1ns / 1ps
module r2i_queue import r2i_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  r2i_item_t item_i,
  input  logic      pop_i,
  output logic      full_o,
  output logic      empty_o,
  output r2i_item_t head_o
);

  r2i_item_t         slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* design/r2i_back.sv */
// Back end: line buffer, filter arithmetic pipeline and output register.
`timescale 1ns / 1ps
module r2i_back import r2i_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  r2i_gains_t       gains_i,
  input  logic             q_empty_i,
  input  r2i_item_t        head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [PIX_W-1:0] pixel_out_o,
  output logic             row_end_o
);

  logic [PIX_W-1:0] row_mem [MAX_WIDTH];

  logic                    adv;
  logic                    s1_v_q, s2_v_q, s3_v_q, out_v_q;
  r2i_item_t               s1_q;
  logic [PIX_W-1:0]        rd_q;
  logic [PIX_W-1:0]        prev_up_q;
  logic [PROD_W-1:0]       ax_q, bu_q, cul_q;
  r2i_ctl_t                s2_ctl_q, s3_ctl_q;
  logic signed [ACC_W-1:0] part_q;
  logic [PIX_W-1:0]        pix_q;
  logic                    end_q;

  logic [PIX_W-1:0]        up, upleft;
  logic [PROD_W-1:0]       bl;
  logic signed [ACC_W-1:0] sum;
  logic [PIX_W-1:0]        y;

  // whole pipeline moves when the output register can take a result
  assign adv   = !out_v_q || !out_stall_i;
  // narrow rows: the needed line buffer entry may still be in flight
  assign pop_o = adv && !q_empty_i &&
                 !(head_i.narrow && (s1_v_q || s2_v_q || s3_v_q));

  assign up     = s1_q.first_row ? '0 : rd_q;
  assign upleft = (s1_q.first_row || s1_q.col == '0) ? '0 : prev_up_q;

  // left recurrence: previous output feeds straight back
  always_comb begin
    bl  = s3_ctl_q.use_left ? PROD_W'(gains_i.b) * PROD_W'(pix_q) : '0;
    sum = part_q + $signed({3'b000, bl});
    if (sum < 0) begin
      y = '0;
    end else if (sum[ACC_W-1:FRAC_W] > (ACC_W - FRAC_W)'(PIX_MAX)) begin
      y = PIX_MAX;
    end else begin
      y = sum[FRAC_W +: PIX_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s3_v_q) begin
      row_mem[s3_ctl_q.col] <= y;
    end
    if (pop_o) begin
      rd_q <= row_mem[head_i.col];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (pop_o) begin
        s1_q <= head_i;
      end
      if (s1_v_q) begin
        ax_q              <= PROD_W'(gains_i.a) * PROD_W'(s1_q.pixel);
        bu_q              <= PROD_W'(gains_i.b) * PROD_W'(up);
        cul_q             <= PROD_W'(gains_i.c) * PROD_W'(upleft);
        prev_up_q         <= up;
        s2_ctl_q.use_left <= s1_q.col != '0;
        s2_ctl_q.last     <= s1_q.last;
        s2_ctl_q.col      <= s1_q.col;
      end
      if (s2_v_q) begin
        part_q   <= $signed({3'b000, ax_q}) + $signed({3'b000, bu_q})
                  - $signed({3'b000, cul_q});
        s3_ctl_q <= s2_ctl_q;
      end
      if (s3_v_q) begin
        pix_q <= y;
        end_q <= s3_ctl_q.last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q  <= pop_o;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      out_v_q <= s3_v_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign pixel_out_o = pix_q;
  assign row_end_o   = end_q;

endmodule

/* design/r2i_checker.sv */
// Port-level checks for the raster 2-D IIR filter, bound to the top level.
`timescale 1ns / 1ps
module r2i_checker import r2i_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 cfg_we_i,
  input logic [CFG_IDX_W-1:0] cfg_idx_i,
  input logic [CFG_W-1:0]     cfg_data_i,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [PIX_W-1:0]     pixel_out_o,
  input logic                 row_end_o
);

  localparam int CAP   = QUEUE_DEPTH + 4;
  localparam int OUT_W = $clog2(CAP + 1);

  logic [OUT_W-1:0] pend_q;
  logic             width_one_q;
  logic             in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      width_one_q <= 1'b0;
    end else begin
      pend_q <= pend_q + OUT_W'(in_acc) - OUT_W'(out_acc);
      if (cfg_we_i && cfg_idx_e'(cfg_idx_i) == CFG_LINE_WIDTH) begin
        width_one_q <= cfg_data_i[LW_W-1:0] == LW_W'(1);
      end
    end
  end

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result valid dropped while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(pixel_out_o) && $stable(row_end_o))
    else $error("result payload changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != '0)
    else $error("result without an outstanding request");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= OUT_W'(CAP))
    else $error("more requests in flight than the pipeline holds");

  a_width_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && width_one_q |-> row_end_o)
    else $error("one-pixel rows must end on every pixel");

endmodule

bind raster_2d_iir_filter r2i_checker u_r2i_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .cfg_data_i  (cfg_data_i),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .pixel_out_o (pixel_out_o),
  .row_end_o   (row_end_o)
);
